### sv/dgcc_pkg.sv
// Shared types and constants for the directed graph cycle check.
// Depends on nothing; imported by every module of the block.
package dgcc_pkg;

	localparam int NODE_W  = 6;
	localparam int COUNT_W = 7;

	// Node numbers on the command port span this many nodes
	localparam int NODE_SPACE = 1 << NODE_W;

	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(64);

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		node_t src_node;
		node_t dst_node;
		logic  edge_valid;
		logic  last;
	} in_item_t;

	typedef struct packed {
		logic acyclic;
		logic bad_edge;
	} out_item_t;

	// One edge write into the adjacency matrix
	typedef struct packed {
		logic  en;
		node_t row;
		node_t col;
	} adj_wr_t;

endpackage

### sv/dgcc_adj_mem.sv
// Adjacency bit matrix: one row per source node, registered read.
// Depends on dgcc_pkg; row valid bits make a cleared row read as zero.
module dgcc_adj_mem import dgcc_pkg::*; #(
	parameter int NN = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  adj_wr_t               wr,
	input  logic                  rd_en,
	input  logic [$clog2(NN)-1:0] rd_row,
	output logic [NN-1:0]         rd_data
);

	localparam int IW = $clog2(NN);

	logic [NN-1:0] adj_mem [NN];
	logic [NN-1:0] row_vld_q;
	logic [NN-1:0] rd_row_q;
	logic          rd_vld_q;
	logic [IW-1:0] wa;
	logic [IW-1:0] wc;
	logic [NN-1:0] wbit;
	logic [NN-1:0] wmask;

	// First write to a stale row rewrites the whole row, later ones set one bit
	assign wa    = wr.row[IW-1:0];
	assign wc    = wr.col[IW-1:0];
	assign wbit  = NN'(1) << wc;
	assign wmask = row_vld_q[wa] ? wbit : '1;

	// Track rows written since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (clear) begin
			row_vld_q <= '0;
		end else if (wr.en) begin
			row_vld_q[wa] <= 1'b1;
		end
	end

	// Write with bit mask; read one row a cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int b = 0; b < NN; b++) begin
				if (wmask[b]) adj_mem[wa][b] <= wbit[b];
			end
		end
		if (rd_en) begin
			rd_row_q <= adj_mem[rd_row];
			rd_vld_q <= row_vld_q[rd_row];
		end
	end

	assign rd_data = rd_vld_q ? rd_row_q : '0;

endmodule

### sv/directed_graph_cycle_check.sv
// Edge load: one edge transfer per cycle while not busy, stored into the adjacency memory in that cycle.
// Check: after the last item the search walks depth first from each unvisited node in use and
// ends early when it finds a cycle; each scan step waits on one adjacency row read. Busy holds
// the input off meanwhile.
// The result strobe comes in the cycle after the search ends; the receiver cannot stall.
// Reset (arst_n low) clears matrix, marks, stack depth and bad flag; node_count resets to 64.
module directed_graph_cycle_check import dgcc_pkg::*; #(
	parameter int MAX_NODES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	input  logic      cfg_we,
	input  count_t    cfg_data,
	output logic      done,
	output out_item_t res
);

	// Only nodes below NODE_SPACE can ever carry an edge
	localparam int NN  = (MAX_NODES < NODE_SPACE) ? MAX_NODES : NODE_SPACE;
	localparam int IW  = $clog2(NN);
	localparam int DW  = $clog2(NN + 1);
	localparam int CAP = (MAX_NODES > 127) ? 127 : MAX_NODES;
	localparam int SW  = IW + COUNT_W;
	localparam count_t CAP_C = COUNT_W'(CAP);
	localparam count_t NN_C  = COUNT_W'(NN);

	typedef enum logic [3:0] {
		S_LOAD = 4'b0001,
		S_ROOT = 4'b0010,
		S_SCAN = 4'b0100,
		S_POP  = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	count_t        node_count_q;
	count_t        root_q, root_d;
	logic [IW-1:0] cur_node_q, cur_node_d;
	count_t        cur_next_q, cur_next_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [NN-1:0] visited_q, visited_d;
	logic [NN-1:0] path_q, path_d;
	logic          bad_q, bad_d;
	logic          done_q, done_d;
	out_item_t     res_q, res_d;

	logic [SW-1:0] stk_mem [NN];
	logic [SW-1:0] stk_rd_q;
	logic          stk_we, stk_re;
	logic [IW-1:0] stk_wa, stk_ra;
	logic [SW-1:0] stk_wd;

	adj_wr_t       adj_wr;
	logic          adj_clear;
	logic          adj_rd_en;
	logic [IW-1:0] adj_rd_row;
	logic [NN-1:0] adj_row;

	count_t        n_use, n_srch;
	logic          accept, edge_bad;
	logic [NN-1:0] cand;
	logic          found;
	logic [IW-1:0] v_idx;
	logic [IW-1:0] root_idx;
	logic [DW-1:0] depth_m1, depth_m2;

	// Lowest set bit of a neighbor vector
	function automatic logic [IW-1:0] first_one(input logic [NN-1:0] m);
		logic [IW-1:0] idx;
		idx = '0;
		for (int i = NN - 1; i >= 0; i--) begin
			if (m[i]) idx = IW'(i);
		end
		return idx;
	endfunction

	// Clamp node count for edge checks and for the search
	assign n_use    = (node_count_q > CAP_C) ? CAP_C : node_count_q;
	assign n_srch   = (n_use > NN_C) ? NN_C : n_use;
	assign edge_bad = ({1'b0, cmd.src_node} >= n_use) || ({1'b0, cmd.dst_node} >= n_use);
	assign accept   = start && (state_q == S_LOAD);
	assign busy     = (state_q != S_LOAD);

	// Neighbors worth a step: in range, at or past the saved position, not finished
	always_comb begin
		for (int i = 0; i < NN; i++) begin
			cand[i] = adj_row[i] && !(visited_q[i] && !path_q[i])
				&& (COUNT_W'(i) >= cur_next_q) && (COUNT_W'(i) < n_srch);
		end
	end
	assign found    = |cand;
	assign v_idx    = first_one(cand);
	assign root_idx = root_q[IW-1:0];
	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);

	// Edge writes go straight to the matrix
	assign adj_wr.en  = accept && cmd.edge_valid && !edge_bad;
	assign adj_wr.row = cmd.src_node;
	assign adj_wr.col = cmd.dst_node;

	// Search sequencer
	always_comb begin
		state_d    = state_q;
		root_d     = root_q;
		cur_node_d = cur_node_q;
		cur_next_d = cur_next_q;
		depth_d    = depth_q;
		visited_d  = visited_q;
		path_d     = path_q;
		bad_d      = bad_q;
		done_d     = 1'b0;
		res_d      = res_q;
		adj_clear  = 1'b0;
		adj_rd_en  = 1'b0;
		adj_rd_row = '0;
		stk_we     = 1'b0;
		stk_wa     = depth_m1[IW-1:0];
		stk_wd     = {cur_node_q, COUNT_W'(v_idx) + COUNT_W'(1)};
		stk_re     = 1'b0;
		stk_ra     = depth_m2[IW-1:0];

		unique case (state_q)
			S_LOAD: begin
				if (accept) begin
					if (cmd.edge_valid && edge_bad) bad_d = 1'b1;
					if (cmd.last) begin
						root_d  = '0;
						state_d = S_ROOT;
					end
				end
			end
			S_ROOT: begin
				if (root_q >= n_srch) begin
					done_d        = 1'b1;
					res_d.acyclic = 1'b1;
				end else if (visited_q[root_idx]) begin
					root_d = root_q + COUNT_W'(1);
				end else begin
					visited_d[root_idx] = 1'b1;
					path_d[root_idx]    = 1'b1;
					cur_node_d          = root_idx;
					cur_next_d          = '0;
					depth_d             = DW'(1);
					adj_rd_en           = 1'b1;
					adj_rd_row          = root_idx;
					state_d             = S_SCAN;
				end
			end
			S_SCAN: begin
				if (found) begin
					if (path_q[v_idx]) begin
						done_d        = 1'b1;
						res_d.acyclic = 1'b0;
					end else begin
						// Descend: save the current node and where to resume it
						stk_we           = 1'b1;
						visited_d[v_idx] = 1'b1;
						path_d[v_idx]    = 1'b1;
						cur_node_d       = v_idx;
						cur_next_d       = '0;
						depth_d          = depth_q + DW'(1);
						adj_rd_en        = 1'b1;
						adj_rd_row       = v_idx;
					end
				end else begin
					// Retreat: drop the node from the path
					path_d[cur_node_q] = 1'b0;
					depth_d            = depth_m1;
					if (depth_q == DW'(1)) begin
						root_d  = root_q + COUNT_W'(1);
						state_d = S_ROOT;
					end else begin
						stk_re  = 1'b1;
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				cur_node_d = stk_rd_q[SW-1:COUNT_W];
				cur_next_d = stk_rd_q[COUNT_W-1:0];
				adj_rd_en  = 1'b1;
				adj_rd_row = stk_rd_q[SW-1:COUNT_W];
				state_d    = S_SCAN;
			end
			default: state_d = S_LOAD;
		endcase

		// Report and clear for the next edge set
		if (done_d) begin
			res_d.bad_edge = bad_q;
			visited_d      = '0;
			path_d         = '0;
			bad_d          = 1'b0;
			depth_d        = '0;
			adj_clear      = 1'b1;
			state_d        = S_LOAD;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			node_count_q <= NODE_COUNT_RST;
			root_q       <= '0;
			depth_q      <= '0;
			visited_q    <= '0;
			path_q       <= '0;
			bad_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			root_q    <= root_d;
			depth_q   <= depth_d;
			visited_q <= visited_d;
			path_q    <= path_d;
			bad_q     <= bad_d;
			done_q    <= done_d;
			if (cfg_we) node_count_q <= cfg_data;
		end
	end

	// Top-of-stack and result payload
	always_ff @(posedge clk) begin
		cur_node_q <= cur_node_d;
		cur_next_q <= cur_next_d;
		res_q      <= res_d;
	end

	// Walk stack: entries below the top, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd_q <= stk_mem[stk_ra];
	end

	dgcc_adj_mem #(
		.NN (NN)
	) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (adj_clear),
		.wr      (adj_wr),
		.rd_en   (adj_rd_en),
		.rd_row  (adj_rd_row),
		.rd_data (adj_row)
	);

	assign done = done_q;
	assign res  = res_q;

endmodule

### sv/dgcc_checker.sv
// Port-level checks for the cycle check block, bound to the top level.
// Depends on dgcc_pkg; sees only the top level's ports.
module dgcc_checker import dgcc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  cmd,
	input logic      done,
	input out_item_t res
);

	// A result ends the search and frees the block
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without a finished search");

	// A result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// The closing transfer starts the search
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.last |=> busy)
		else $error("last transfer did not start the search");

	// Only a closing transfer starts the search
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(cmd.last))
		else $error("search started without a last transfer");

endmodule

bind directed_graph_cycle_check dgcc_checker u_dgcc_checker (.*);

### verif/tb_directed_graph_cycle_check.sv
// Self-checking testbench for directed_graph_cycle_check: sends edge sets, predicts each verdict.
// Depends on dgcc_pkg (item types, node space, reset node count) and the block's RTL.
module tb_directed_graph_cycle_check import dgcc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Idle cycles after each drain, and the drain window at the end of the run
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES    = 4 * NODE_SPACE + 8;

	logic      clk      = 1'b0;
	logic      arst_n   = 1'b0;
	logic      start    = 1'b0;
	logic      busy;
	in_item_t  cmd      = '0;
	logic      cfg_we   = 1'b0;
	count_t    cfg_data = '0;
	logic      done;
	out_item_t res;

	// Predictor state: edge matrix, out-of-range flag, node count register
	logic [NODE_SPACE-1:0] edge_rows [NODE_SPACE];
	logic                  bad_flag = 1'b0;
	count_t                node_reg = NODE_COUNT_RST;

	out_item_t expected_verdicts [$];
	out_item_t verdict_due;
	int        mismatch_count = 0;
	int        idle_pct       = 0;
	int        items_done     = 0;

	directed_graph_cycle_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.res      (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#25_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int active_nodes();
		return (node_reg > NODE_SPACE) ? NODE_SPACE : int'(node_reg);
	endfunction

	function automatic void clear_graph();
		for (int r = 0; r < NODE_SPACE; r++)
			edge_rows[r] = '0;
		bad_flag = 1'b0;
	endfunction

	// Depth-first walk from every unseen node with an explicit trail of (node, next column)
	function automatic bit graph_is_acyclic(int n);
		logic [NODE_SPACE-1:0] seen;
		logic [NODE_SPACE-1:0] on_trail;
		int trail_node [NODE_SPACE];
		int trail_pos  [NODE_SPACE];
		int sp, u, v, r;
		seen = '0;
		on_trail = '0;
		for (r = 0; r < n; r++) begin
			if (seen[r])
				continue;
			sp = 1;
			trail_node[0] = r;
			trail_pos[0] = 0;
			seen[r] = 1'b1;
			on_trail[r] = 1'b1;
			while (sp > 0) begin
				u = trail_node[sp-1];
				v = trail_pos[sp-1];
				while (v < n && !edge_rows[u][v])
					v++;
				if (v < n) begin
					trail_pos[sp-1] = v + 1;
					if (on_trail[v])
						return 1'b0;
					if (!seen[v] && sp < NODE_SPACE) begin
						seen[v] = 1'b1;
						on_trail[v] = 1'b1;
						trail_node[sp] = v;
						trail_pos[sp] = 0;
						sp++;
					end
				end else begin
					on_trail[u] = 1'b0;
					sp--;
				end
			end
		end
		return 1'b1;
	endfunction

	// Fold one accepted transfer into the predictor; a closing item queues a verdict
	function automatic void absorb_item(in_item_t item);
		int n;
		out_item_t verdict;
		n = active_nodes();
		if (item.edge_valid) begin
			if (int'(item.src_node) >= n || int'(item.dst_node) >= n)
				bad_flag = 1'b1;
			else
				edge_rows[item.src_node][item.dst_node] = 1'b1;
		end
		if (item.last) begin
			verdict.acyclic = graph_is_acyclic(n);
			verdict.bad_edge = bad_flag;
			expected_verdicts = {expected_verdicts, verdict};
			clear_graph();
		end
	endfunction

	function automatic in_item_t edge_item(int src, int dst, bit valid, bit closing);
		in_item_t item;
		item.src_node = node_t'(src);
		item.dst_node = node_t'(dst);
		item.edge_valid = valid;
		item.last = closing;
		return item;
	endfunction

	function automatic count_t pick_node_count();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return count_t'($urandom_range(2, 12));
		else if (roll < 70)
			return count_t'($urandom_range(13, 40));
		else if (roll < 85)
			return count_t'(NODE_SPACE);
		else if (roll < 90)
			return count_t'(0);
		else if (roll < 95)
			return count_t'(1);
		else
			return count_t'($urandom_range(NODE_SPACE + 1, 127));
	endfunction

	// Check each result against the oldest verdict in the queue
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("result with no verdict pending");
			end else begin
				verdict_due = expected_verdicts.pop_front();
				if (res.acyclic !== verdict_due.acyclic)
					report_mismatch($sformatf("acyclic got %b want %b",
						res.acyclic, verdict_due.acyclic));
				if (res.bad_edge !== verdict_due.bad_edge)
					report_mismatch($sformatf("bad_edge got %b want %b",
						res.bad_edge, verdict_due.bad_edge));
			end
		end
	end

	// Offer one item, idling each cycle with the set chance first; start stays high after
	task automatic send_item(in_item_t item);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (busy);
		absorb_item(item);
	endtask

	// Drop start and hold until every pending verdict has come back
	task automatic wait_drain();
		start <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_count(count_t value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		node_reg = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Self-loops, empty closing item, ignored item, back edge, diamond with duplicate, two-node loop
	task automatic test_basic_graphs();
		send_item(edge_item(0, 0, 1'b1, 1'b1));
		send_item(edge_item(0, 0, 1'b0, 1'b1));
		send_item(edge_item(5, 9, 1'b0, 1'b0));
		send_item(edge_item(0, 1, 1'b1, 1'b0));
		send_item(edge_item(1, 2, 1'b1, 1'b0));
		send_item(edge_item(2, 0, 1'b1, 1'b1));
		send_item(edge_item(0, 1, 1'b1, 1'b0));
		send_item(edge_item(0, 2, 1'b1, 1'b0));
		send_item(edge_item(1, 3, 1'b1, 1'b0));
		send_item(edge_item(2, 3, 1'b1, 1'b0));
		send_item(edge_item(2, 3, 1'b1, 1'b1));
		send_item(edge_item(63, 63, 1'b1, 1'b1));
		send_item(edge_item(0, 63, 1'b1, 1'b0));
		send_item(edge_item(63, 0, 1'b1, 1'b1));
		wait_drain();
	endtask

	// Node count of one, zero, above the node space, and a change in the middle of a set
	task automatic test_node_count_limits();
		write_node_count(count_t'(1));
		send_item(edge_item(0, 0, 1'b1, 1'b1));
		send_item(edge_item(0, 1, 1'b1, 1'b1));
		wait_drain();
		write_node_count(count_t'(0));
		send_item(edge_item(0, 0, 1'b1, 1'b1));
		wait_drain();
		write_node_count(count_t'(127));
		send_item(edge_item(63, 62, 1'b1, 1'b0));
		send_item(edge_item(62, 63, 1'b1, 1'b1));
		wait_drain();
		write_node_count(count_t'(NODE_SPACE));
		send_item(edge_item(40, 41, 1'b1, 1'b0));
		send_item(edge_item(41, 40, 1'b1, 1'b0));
		wait_drain();
		write_node_count(count_t'(32));
		send_item(edge_item(0, 0, 1'b0, 1'b1));
		wait_drain();
	endtask

	// One edge set: forward edges over a shuffled node order, maybe one back edge, some noise
	task automatic send_random_graph();
		int n, m, hi, i, j, k, roll, loop_at, tmp;
		bit with_loop;
		int order [NODE_SPACE];
		in_item_t item;
		n = active_nodes();
		hi = (n > 0) ? n - 1 : 0;
		for (k = 0; k < NODE_SPACE; k++)
			order[k] = k;
		for (k = n - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		m = $urandom_range(0, (n < 44) ? 2 * n + 2 : 90);
		with_loop = $urandom_range(1);
		loop_at = (m > 0) ? $urandom_range(m - 1) : 0;
		for (k = 0; k < m; k++) begin
			roll = $urandom_range(99);
			if (with_loop && k == loop_at) begin
				i = $urandom_range(hi);
				j = $urandom_range(i, hi);
				item = edge_item(order[j], order[i], 1'b1, 1'b0);
			end else if (roll < 4) begin
				item = edge_item($urandom_range(63), $urandom_range(63), 1'b0, 1'b0);
			end else if (roll < 9 || n < 2) begin
				item = edge_item($urandom_range(63), $urandom_range(63), 1'b1, 1'b0);
			end else begin
				i = $urandom_range(n - 2);
				j = $urandom_range(i + 1, n - 1);
				item = edge_item(order[i], order[j], 1'b1, 1'b0);
			end
			send_item(item);
			if (item.edge_valid)
				items_done++;
			// Rarely retune the node count in the middle of the set
			if ($urandom_range(99) < 2) begin
				wait_drain();
				write_node_count(pick_node_count());
			end
		end
		if (n >= 2 && $urandom_range(1)) begin
			i = $urandom_range(n - 2);
			j = $urandom_range(i + 1, n - 1);
			item = edge_item(order[i], order[j], 1'b1, 1'b1);
		end else begin
			item = edge_item($urandom_range(63), $urandom_range(63), 1'b0, 1'b1);
		end
		send_item(item);
		items_done++;
	endtask

	task automatic test_random_graphs(int budget);
		int goal;
		goal = items_done + budget;
		wait_drain();
		write_node_count(pick_node_count());
		while (items_done < goal) begin
			send_random_graph();
			if ($urandom_range(99) < 25) begin
				wait_drain();
				write_node_count(pick_node_count());
			end else if ($urandom_range(99) < 8) begin
				wait_drain();
			end
		end
		wait_drain();
	endtask

	initial begin
		clear_graph();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_graphs();
		test_node_count_limits();
		idle_pct = 11;
		test_random_graphs(600);
		idle_pct = 75;
		test_random_graphs(600);
		idle_pct = 0;
		test_random_graphs(600);
		wait_drain();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_verdicts.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/dgcc_pkg.sv
sv/dgcc_adj_mem.sv
sv/directed_graph_cycle_check.sv
sv/dgcc_checker.sv
verif/tb_directed_graph_cycle_check.sv
